// ===== hw/rtl/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdd_pkg: shared types and constants of the PalmDoc decompressor
// Byte classes, controller states and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package pdd_pkg;

  // History window; the address arithmetic wraps, so keep it a power of two
  localparam int unsigned HistDepth = 2048;
  localparam int unsigned HistAw    = $clog2(HistDepth);

  // Byte codes of the compressed stream
  localparam logic [7:0] RunLo   = 8'h01;
  localparam logic [7:0] RunHi   = 8'h08;
  localparam logic [7:0] RefLo   = 8'h80;
  localparam logic [7:0] RefHi   = 8'hBF;
  localparam logic [7:0] SpaceLo = 8'hC0;
  localparam logic [7:0] Ascii   = 8'h7F;
  localparam logic [7:0] SpaceCh = 8'h20;

  // Back-reference fields
  localparam int unsigned DistW  = 11;
  localparam int unsigned LenW   = 4;
  localparam logic [LenW-1:0] LenBase = 4'd3;

  typedef enum logic [1:0] {
    CLS_LIT,
    CLS_RUN,
    CLS_REF,
    CLS_SPACE
  } byte_cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_REFB,
    ST_LAUNCH,
    ST_COPY,
    ST_SECOND
  } state_e;

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_SPACE,
    SEL_SECOND,
    SEL_HIST
  } out_sel_e;

  typedef struct packed {
    logic     accept;     // take the input request
    logic     emit;       // load the output register
    out_sel_e sel;        // source of the emitted byte
    logic     hist_we;    // record the emitted byte in the history
    logic     last;       // final byte of this request
    logic     load_pend;  // capture the low six bits of the control byte
    logic     dec_pend;   // one literal of the run consumed
    logic     save_second;// keep the second byte of a space pair
    logic     start_ref;  // compute copy source and length
    logic     rd_issue;   // read the history at the copy source
  } cmd_t;

  typedef struct packed {
    logic      mode;      // compressed mode register
    logic      out_free;  // output register can take a byte this cycle
    byte_cls_e cls;       // class of the offered input byte
    logic      pend_one;  // one literal left in the run
    logic      cnt_one;   // one byte left in the copy
  } stat_t;

endpackage

// ===== hw/rtl/pdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdd_ctrl: decode sequencer
// Tracks the stream phase and steps the datapath through literals, space
// pairs and history copies.
// ----------------------------------------------------------------------------
module pdd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  pdd_pkg::stat_t stat_i,
  output logic           in_stall_o,
  output pdd_pkg::cmd_t  cmd_o
);

  pdd_pkg::state_e state_q, state_d;
  logic            acc_state;
  logic            take;

  // Input is taken only in a phase-holding state with room at the output
  assign acc_state = (state_q == pdd_pkg::ST_IDLE) || (state_q == pdd_pkg::ST_RUN) ||
                     (state_q == pdd_pkg::ST_REFB);
  assign take       = acc_state && in_valid_i && stat_i.out_free;
  assign in_stall_o = !(acc_state && stat_i.out_free);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdd_pkg::ST_IDLE: begin
        if (take && stat_i.mode) begin
          unique case (stat_i.cls)
            pdd_pkg::CLS_RUN:   state_d = pdd_pkg::ST_RUN;
            pdd_pkg::CLS_REF:   state_d = pdd_pkg::ST_REFB;
            pdd_pkg::CLS_SPACE: state_d = pdd_pkg::ST_SECOND;
            default:            state_d = pdd_pkg::ST_IDLE;
          endcase
        end
      end
      pdd_pkg::ST_RUN: begin
        if (take && stat_i.mode && stat_i.pend_one) state_d = pdd_pkg::ST_IDLE;
      end
      pdd_pkg::ST_REFB: begin
        if (take && stat_i.mode) state_d = pdd_pkg::ST_LAUNCH;
      end
      pdd_pkg::ST_LAUNCH: state_d = pdd_pkg::ST_COPY;
      pdd_pkg::ST_COPY: begin
        if (stat_i.out_free && stat_i.cnt_one) state_d = pdd_pkg::ST_IDLE;
      end
      pdd_pkg::ST_SECOND: begin
        if (stat_i.out_free) state_d = pdd_pkg::ST_IDLE;
      end
      default: state_d = pdd_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.sel    = pdd_pkg::SEL_IN;
    cmd_o.accept = take;
    unique case (state_q)
      pdd_pkg::ST_IDLE: begin
        if (take && !stat_i.mode) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
        end else if (take) begin
          unique case (stat_i.cls)
            pdd_pkg::CLS_RUN, pdd_pkg::CLS_REF: cmd_o.load_pend = 1'b1;
            pdd_pkg::CLS_SPACE: begin
              cmd_o.emit        = 1'b1;
              cmd_o.sel         = pdd_pkg::SEL_SPACE;
              cmd_o.hist_we     = 1'b1;
              cmd_o.save_second = 1'b1;
            end
            default: begin
              cmd_o.emit    = 1'b1;
              cmd_o.hist_we = 1'b1;
              cmd_o.last    = 1'b1;
            end
          endcase
        end
      end
      pdd_pkg::ST_RUN: begin
        if (take) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last     = 1'b1;
          cmd_o.hist_we  = stat_i.mode;
          cmd_o.dec_pend = stat_i.mode;
        end
      end
      pdd_pkg::ST_REFB: begin
        if (take && !stat_i.mode) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
        end else if (take) begin
          cmd_o.start_ref = 1'b1;
        end
      end
      pdd_pkg::ST_LAUNCH: cmd_o.rd_issue = 1'b1;
      pdd_pkg::ST_COPY: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = pdd_pkg::SEL_HIST;
          cmd_o.hist_we  = 1'b1;
          cmd_o.last     = stat_i.cnt_one;
          cmd_o.rd_issue = !stat_i.cnt_one;
        end
      end
      pdd_pkg::ST_SECOND: begin
        if (stat_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.sel     = pdd_pkg::SEL_SECOND;
          cmd_o.hist_we = 1'b1;
          cmd_o.last    = 1'b1;
        end
      end
      default: cmd_o.accept = 1'b0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/pdd_datapath.sv =====
// ----------------------------------------------------------------------------
// pdd_datapath: history window, copy pointers and output register
// Classifies the offered byte, keeps the run and copy counters and drives
// the registered output with a read-during-write bypass on the history.
// ----------------------------------------------------------------------------
module pdd_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic [7:0]     in_byte_i,
  input  logic           out_stall_i,
  input  pdd_pkg::cmd_t  cmd_i,
  output pdd_pkg::stat_t stat_o,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  localparam int unsigned Aw = pdd_pkg::HistAw;

  logic                     mode_q;
  logic [5:0]               pend_q, pend_d;
  logic [Aw-1:0]            wp_q, src_q;
  logic [pdd_pkg::LenW-1:0] cnt_q;
  logic [7:0]               second_q;
  logic                     out_valid_q, out_last_q;
  logic [7:0]               out_byte_q, emit_byte;
  logic [7:0]               mem [pdd_pkg::HistDepth];
  logic [7:0]               rd_q, byp_data_q, hist_byte;
  logic                     byp_q;
  logic [pdd_pkg::DistW-1:0] ref_dist;
  logic                     out_free;
  pdd_pkg::byte_cls_e       in_cls;

  assign out_free = !out_valid_q || !out_stall_i;

  // Classify the offered byte
  always_comb begin
    priority if (in_byte_i >= pdd_pkg::RunLo && in_byte_i <= pdd_pkg::RunHi) begin
      in_cls = pdd_pkg::CLS_RUN;
    end else if (in_byte_i >= pdd_pkg::RefLo && in_byte_i <= pdd_pkg::RefHi) begin
      in_cls = pdd_pkg::CLS_REF;
    end else if (in_byte_i >= pdd_pkg::SpaceLo) begin
      in_cls = pdd_pkg::CLS_SPACE;
    end else begin
      in_cls = pdd_pkg::CLS_LIT;
    end
  end

  // Status towards the sequencer
  assign stat_o = '{
    mode:     mode_q,
    out_free: out_free,
    cls:      in_cls,
    pend_one: (pend_q == 6'd1),
    cnt_one:  (cnt_q == pdd_pkg::LenW'(1))
  };

  // Distance: bits 13..3 of the reference pair
  assign ref_dist = {pend_q[5:0], in_byte_i[7:3]};

  // Pick the emitted byte
  assign hist_byte = byp_q ? byp_data_q : rd_q;
  always_comb begin
    unique case (cmd_i.sel)
      pdd_pkg::SEL_IN:     emit_byte = in_byte_i;
      pdd_pkg::SEL_SPACE:  emit_byte = pdd_pkg::SpaceCh;
      pdd_pkg::SEL_SECOND: emit_byte = second_q;
      pdd_pkg::SEL_HIST:   emit_byte = hist_byte;
      default:             emit_byte = in_byte_i;
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.load_pend) pend_d = in_byte_i[5:0];
    else if (cmd_i.dec_pend) pend_d = pend_q - 6'd1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      pend_q      <= '0;
      wp_q        <= '0;
      src_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      pend_q <= pend_d;
      if (cmd_i.hist_we) wp_q <= wp_q + Aw'(1);
      if (cmd_i.start_ref) begin
        src_q <= wp_q - Aw'(ref_dist);
        cnt_q <= pdd_pkg::LenW'(in_byte_i[2:0]) + pdd_pkg::LenBase;
      end else begin
        if (cmd_i.rd_issue) src_q <= src_q + Aw'(1);
        if (cmd_i.emit && cmd_i.sel == pdd_pkg::SEL_HIST) cnt_q <= cnt_q - pdd_pkg::LenW'(1);
      end
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.save_second) second_q <= in_byte_i & pdd_pkg::Ascii;
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= cmd_i.last;
    end
  end

  // History write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_we) mem[wp_q] <= emit_byte;
  end

  // History read port; forward a byte written at the address being read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_q       <= mem[src_q];
      byp_q      <= cmd_i.hist_we && (wp_q == src_q);
      byp_data_q <= emit_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hw/rtl/palmdoc_decompressor.sv =====
// ----------------------------------------------------------------------------
// palmdoc_decompressor: PalmDoc LZ77 stream decompressor
// One compressed byte per input request, zero to ten text bytes out.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   in_byte_i
//   out      source     out_valid_o / out_stall_i out_byte_o, out_last_o
//   cfg      sink       cfg_we_i                  cfg_wdata_i (compressed mode)
//
// A literal, run byte, control byte or pass-through byte is handled as it is
// taken; a space pair emits the space, then its second byte. The second byte
// of a back-reference starts a copy of 3 to 10 bytes: a history read launches
// it, then one byte per cycle goes out through the single read port of the
// history RAM, and a stalled output holds the copy in place without losing
// bytes. Reset clears phase, pointers and output valid, not the history RAM.
// ----------------------------------------------------------------------------
module palmdoc_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  pdd_pkg::cmd_t  cmd;
  pdd_pkg::stat_t stat;

  // Sequencer
  pdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // History and output
  pdd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (in_byte_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for palmdoc_decompressor
// Drives compressed bytes and register writes, predicts the text bytes each
// request produces with an internal decoder and history window, and compares
// every output byte and its last flag in order.
// ----------------------------------------------------------------------------
module testbench;

  // Decoder phases of the predictor
  typedef enum logic [1:0] {
    DEC_IDLE,
    DEC_RUN,
    DEC_REF
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  // Predicts the text stream and checks the block's output against it
  class text_scoreboard;
    bit              mode;
    dec_phase_e      phase;
    logic [5:0]      pend;
    logic [7:0]      hist [pdd_pkg::HistDepth];
    logic [pdd_pkg::HistAw-1:0] wpos;
    int unsigned     filled;
    text_byte_t      text_q[$];
    text_byte_t      emitted[$];
    int unsigned     errors;

    function new();
      mode   = 1'b1;
      phase  = DEC_IDLE;
      pend   = '0;
      wpos   = '0;
      filled = 0;
      errors = 0;
      foreach (hist[i]) hist[i] = '0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Record one text byte in the history and in this request's output
    function void keep(logic [7:0] b);
      text_byte_t t;
      t.data = b;
      t.last = 1'b0;
      hist[wpos] = b;
      wpos++;
      if (filled < pdd_pkg::HistDepth) filled++;
      emitted.push_back(t);
    endfunction

    // A back-reference with these distance bits can reach written history
    function bit ref_reach_ok(logic [5:0] hi);
      int unsigned base;
      base = 32'(hi) << 5;
      if (filled >= pdd_pkg::HistDepth) return 1'b1;
      return (((base == 0) ? 1 : base) <= filled);
    endfunction

    // Work out the text bytes that one accepted request produces
    function void note_request(logic [7:0] b);
      text_byte_t                  t;
      logic [13:0]                 pair;
      logic [pdd_pkg::DistW-1:0]   ref_dist;
      logic [pdd_pkg::HistAw-1:0]  src;
      int unsigned                 len;
      emitted.delete();
      if (!mode) begin
        t.data = b;
        t.last = 1'b1;
        text_q.push_back(t);
        return;
      end
      case (phase)
        DEC_RUN: begin
          keep(b);
          pend = pend - 6'd1;
          if (pend == 0) phase = DEC_IDLE;
        end
        DEC_REF: begin
          pair     = {pend, b};
          ref_dist = pair[13:3];
          len      = int'(b[2:0]) + int'(pdd_pkg::LenBase);
          src      = wpos - ref_dist;
          for (int k = 0; k < len; k++) begin
            keep(hist[src]);
            src++;
          end
          pend  = '0;
          phase = DEC_IDLE;
        end
        default: begin
          phase = DEC_IDLE;
          if (b >= pdd_pkg::RunLo && b <= pdd_pkg::RunHi) begin
            pend  = b[5:0];
            phase = DEC_RUN;
          end else if (b >= pdd_pkg::RefLo && b <= pdd_pkg::RefHi) begin
            pend  = b[5:0];
            phase = DEC_REF;
          end else if (b >= pdd_pkg::SpaceLo) begin
            keep(pdd_pkg::SpaceCh);
            keep(b & pdd_pkg::Ascii);
          end else begin
            keep(b);
          end
        end
      endcase
      if (emitted.size() > 0) emitted[$].last = 1'b1;
      foreach (emitted[i]) text_q.push_back(emitted[i]);
    endfunction

    // Compare one output byte with the oldest expected one
    task check_text(logic [7:0] data, logic last);
      text_byte_t t;
      if (text_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", data, last));
        return;
      end
      t = text_q.pop_front();
      if (data !== t.data)
        report($sformatf("byte %02h, expected %02h", data, t.data));
      if (last !== t.last)
        report($sformatf("last %0b on byte %02h, expected %0b", last, data, t.last));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  text_scoreboard sb = new();

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;

  palmdoc_decompressor u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check each accepted output byte, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_text(out_byte_o, out_last_o);
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Offer one compressed byte, hold it until taken, then predict its text
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(b);
    items_sent++;
  endtask

  // Let the block drain, then write the compressed mode register
  task automatic write_mode(bit m);
    in_valid_i <= 1'b0;
    while (sb.text_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.mode  = m;
  endtask

  // First byte of a back-reference: distance bits 10..5, never past written data
  function automatic logic [7:0] ref_head();
    int unsigned hi_max, hi, r;
    hi_max = (sb.filled >= pdd_pkg::HistDepth) ? 63 : sb.filled / 32;
    r = $urandom_range(0, 99);
    if (r < 25) hi = 0;
    else if (r < 40) hi = hi_max;
    else hi = $urandom_range(0, hi_max);
    return pdd_pkg::RefLo | 8'(hi);
  endfunction

  // Second byte of a back-reference: low distance bits and length
  function automatic logic [7:0] ref_tail(logic [5:0] hi);
    int unsigned base, lo_min, lo_max, lo, r;
    logic [2:0]  len_code;
    base = 32'(hi) << 5;
    if (sb.filled >= pdd_pkg::HistDepth) begin
      lo_min = 0;
      lo_max = 31;
    end else begin
      lo_min = (base == 0) ? 1 : 0;
      lo_max = (sb.filled - base > 31) ? 31 : sb.filled - base;
    end
    r = $urandom_range(0, 99);
    if (r < 30) lo = lo_min;
    else if (r < 50) lo = lo_max;
    else lo = $urandom_range(lo_min, lo_max);
    len_code = $urandom_range(0, 1) ? 3'h7 : 3'($urandom_range(0, 7));
    return {lo[4:0], len_code};
  endfunction

  // Next byte of a mostly well-formed compressed stream
  function automatic logic [7:0] next_stream_byte();
    logic [7:0]  b;
    int unsigned r;
    case (sb.phase)
      DEC_RUN: b = 8'($urandom);
      DEC_REF: b = ref_tail(sb.pend);
      default: begin
        r = $urandom_range(0, 99);
        if (r < 40 && sb.filled > 0) b = ref_head();
        else if (r < 55) b = 8'($urandom_range(pdd_pkg::RunLo, pdd_pkg::RunHi));
        else if (r < 68) b = 8'($urandom_range(pdd_pkg::SpaceLo, 255));
        else if (r < 90)
          b = ($urandom_range(0, 9) == 0) ? 8'h00 :
              8'($urandom_range(pdd_pkg::RunHi + 1, pdd_pkg::Ascii));
        else begin
          b = 8'($urandom);
          if (b >= pdd_pkg::RefLo && b <= pdd_pkg::RefHi && !sb.ref_reach_ok(b[5:0]))
            b = pdd_pkg::Ascii;
        end
      end
    endcase
    return b;
  endfunction

  initial begin
    logic [7:0]  directed_q[$];
    int unsigned ph, n;
    bit          m;
    directed_q = '{8'h00, pdd_pkg::Ascii, 8'h09,
                   pdd_pkg::RunLo, 8'hFF,
                   pdd_pkg::RunHi, 8'h00, 8'hFF, pdd_pkg::RefLo, pdd_pkg::SpaceLo,
                   pdd_pkg::RunLo, 8'h55, 8'hAA, pdd_pkg::Ascii,
                   pdd_pkg::SpaceLo, 8'hFF,
                   pdd_pkg::RefLo, 8'h08, pdd_pkg::RefLo, 8'h0F,
                   pdd_pkg::RefLo, 8'h80};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: literals, runs, space pairs, short and overlapping copies
    write_mode(1'b1);
    foreach (directed_q[i]) send_byte(directed_q[i]);

    // Random phases; a phase may end mid-sequence so a mode change lands
    // inside a decode.
    ph = 0;
    do begin
      m = (ph % 3 != 2);
      write_mode(m);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 59; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      n = m ? 80 : 25;
      repeat (n) send_byte(m ? next_stream_byte() : 8'($urandom));
      ph++;
    end while (items_sent < 430);

    // Drain and settle
    in_valid_i <= 1'b0;
    while (sb.text_q.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS palmdoc_decompressor");
    end else begin
      $display("FAIL palmdoc_decompressor");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("FAIL palmdoc_decompressor");
    $finish;
  end

endmodule
